/* rtl/cdsm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cdsm_pkg;

	// Opcodes of one input word
	localparam logic [3:0] OP_REFRESH   = 4'd0;
	localparam logic [3:0] OP_INC_HOUR  = 4'd1;
	localparam logic [3:0] OP_INC_MIN   = 4'd2;
	localparam logic [3:0] OP_INC_SEC   = 4'd3;
	localparam logic [3:0] OP_DEC_HOUR  = 4'd4;
	localparam logic [3:0] OP_DEC_MIN   = 4'd5;
	localparam logic [3:0] OP_DEC_SEC   = 4'd6;
	localparam logic [3:0] OP_INC_YEAR  = 4'd7;
	localparam logic [3:0] OP_INC_MONTH = 4'd8;
	localparam logic [3:0] OP_INC_DAY   = 4'd9;
	localparam logic [3:0] OP_DEC_YEAR  = 4'd10;
	localparam logic [3:0] OP_DEC_MONTH = 4'd11;
	localparam logic [3:0] OP_DEC_DAY   = 4'd12;
	localparam logic [3:0] OP_TIME_SET  = 4'd13;
	localparam logic [3:0] OP_DATE_SET  = 4'd14;

	// Edit modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_TIME = 2'd1;
	localparam logic [1:0] MODE_DATE = 2'd2;

	// Control fields shared by the time and date units
	typedef struct packed {
		logic [3:0] opcode;
		logic       press_valid;
		logic [1:0] mode;
	} cdsm_ctl_t;

endpackage

`default_nettype wire

/* rtl/cdsm_time_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module cdsm_time_unit (
	input  wire cdsm_pkg::cdsm_ctl_t ctl,
	input  wire logic [4:0]          hour,
	input  wire logic [5:0]          minute,
	input  wire logic [5:0]          second,
	input  wire logic [4:0]          clock_hour,
	input  wire logic [5:0]          clock_minute,
	input  wire logic [5:0]          clock_second,
	output logic      [4:0]          hour_n,
	output logic      [5:0]          minute_n,
	output logic      [5:0]          second_n
);
	import cdsm_pkg::*;

	localparam logic [4:0] HOUR_TOP = 5'd23;
	localparam logic [5:0] MS_TOP   = 6'd59;

	always_comb begin
		hour_n   = hour;
		minute_n = minute;
		second_n = second;
		if (ctl.opcode == OP_REFRESH) begin
			if (ctl.mode != MODE_TIME) begin
				hour_n   = clock_hour;
				minute_n = clock_minute;
				second_n = clock_second;
			end
		end else if (ctl.press_valid && ctl.mode == MODE_TIME) begin
			unique case (ctl.opcode)
				OP_INC_HOUR: hour_n = (hour >= HOUR_TOP) ? 5'd0 : hour + 5'd1;
				OP_INC_MIN:  minute_n = (minute >= MS_TOP) ? 6'd0 : minute + 6'd1;
				OP_INC_SEC:  second_n = (second >= MS_TOP) ? 6'd0 : second + 6'd1;
				OP_DEC_HOUR: hour_n = (hour == 5'd0 || hour > HOUR_TOP) ?
					HOUR_TOP : hour - 5'd1;
				OP_DEC_MIN:  minute_n = (minute == 6'd0 || minute > MS_TOP) ?
					MS_TOP : minute - 6'd1;
				OP_DEC_SEC:  second_n = (second == 6'd0 || second > MS_TOP) ?
					MS_TOP : second - 6'd1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/cdsm_date_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

module cdsm_date_unit (
	input  wire cdsm_pkg::cdsm_ctl_t ctl,
	input  wire logic [11:0]         year,
	input  wire logic [3:0]          month,
	input  wire logic [4:0]          day,
	input  wire logic [11:0]         clock_year,
	input  wire logic [3:0]          clock_month,
	input  wire logic [4:0]          clock_day,
	output logic      [11:0]         year_n,
	output logic      [3:0]          month_n,
	output logic      [4:0]          day_n
);
	import cdsm_pkg::*;

	localparam logic [11:0] YEAR_MIN = 12'd2000;
	localparam logic [11:0] YEAR_MAX = 12'd2099;
	localparam logic [3:0]  MONTH_MAX = 4'd12;
	// floor(y/25) = (y * 5243) >> 17, exact for every 12-bit y
	localparam logic [12:0] RECIP_25 = 13'd5243;
	localparam logic [4:0]  TWENTY_FIVE = 5'd25;

	logic        date_edit;
	logic        clamp;
	logic [24:0] prod;
	logic [7:0]  quot;
	logic [11:0] rem25;
	logic        leap;
	logic [4:0]  len;
	logic [5:0]  day_inc;

	assign date_edit = ctl.press_valid && ctl.mode == MODE_DATE;

	// Year and month first; the day works against the updated month
	always_comb begin
		year_n  = year;
		month_n = month;
		clamp   = 1'b0;
		if (ctl.opcode != OP_REFRESH && date_edit) begin
			unique case (ctl.opcode)
				OP_INC_YEAR: begin
					year_n = (year >= YEAR_MIN && year < YEAR_MAX) ? year + 12'd1 : YEAR_MIN;
					clamp  = 1'b1;
				end
				OP_DEC_YEAR: begin
					year_n = (year > YEAR_MIN && year <= YEAR_MAX) ? year - 12'd1 : YEAR_MAX;
					clamp  = 1'b1;
				end
				OP_INC_MONTH: begin
					month_n = (month >= MONTH_MAX) ? 4'd1 : month + 4'd1;
					clamp   = 1'b1;
				end
				OP_DEC_MONTH: begin
					month_n = (month <= 4'd1 || month > MONTH_MAX) ? MONTH_MAX : month - 4'd1;
					clamp   = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Leap rule: divisible by 4, and not by 100 unless by 400 (16 and 25)
	assign prod  = {13'd0, year_n} * {12'd0, RECIP_25};
	assign quot  = prod[24:17];
	assign rem25 = year_n - ({4'd0, quot} * {7'd0, TWENTY_FIVE});
	assign leap  = (year_n[1:0] == 2'd0) && ((rem25 != 12'd0) || (year_n[3:0] == 4'd0));

	always_comb begin
		case (month_n)
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
	end

	assign day_inc = {1'b0, day} + 6'd1;

	always_comb begin
		day_n = day;
		if (ctl.opcode == OP_REFRESH) begin
			if (ctl.mode != MODE_DATE) begin
				day_n = clock_day;
			end
		end else if (date_edit) begin
			if (ctl.opcode == OP_INC_DAY) begin
				day_n = (day_inc > {1'b0, len}) ? 5'd1 : day_inc[4:0];
			end else if (ctl.opcode == OP_DEC_DAY) begin
				day_n = (day <= 5'd1) ? len : day - 5'd1;
			end else if (clamp && day > len) begin
				day_n = len;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/clock_date_set_mode_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

// A word accepted at the input is registered, and its result is registered
// once the input stage advances. Throughput: one word per cycle unless the
// result is held; the held-value registers double as the result register,
// so the input stage advances whenever that register is empty or taken.
// Reset (arst_n low): edit mode idle, all held values and strobes zero.
module clock_date_set_mode_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [3:0]  opcode,
	input  wire logic        press_valid,
	input  wire logic [4:0]  clock_hour,
	input  wire logic [5:0]  clock_minute,
	input  wire logic [5:0]  clock_second,
	input  wire logic [11:0] clock_year,
	input  wire logic [3:0]  clock_month,
	input  wire logic [4:0]  clock_day,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic      [1:0]  mode,
	output logic      [4:0]  shown_hour,
	output logic      [5:0]  shown_minute,
	output logic      [5:0]  shown_second,
	output logic      [11:0] shown_year,
	output logic      [3:0]  shown_month,
	output logic      [4:0]  shown_day,
	output logic             write_time,
	output logic             write_date
);
	import cdsm_pkg::*;

	// Input stage
	logic        valid_s1;
	logic [3:0]  opcode_s1;
	logic        press_s1;
	logic [4:0]  c_hour_s1;
	logic [5:0]  c_minute_s1;
	logic [5:0]  c_second_s1;
	logic [11:0] c_year_s1;
	logic [3:0]  c_month_s1;
	logic [4:0]  c_day_s1;

	// Held state, which is also the result shown on the output
	logic [1:0]  mode_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic        wt_q;
	logic        wd_q;
	logic        result_valid_q;

	logic        advance;
	cdsm_ctl_t   ctl;
	logic [1:0]  mode_n;
	logic        wt_n;
	logic        wd_n;
	logic [4:0]  hour_n;
	logic [5:0]  minute_n;
	logic [5:0]  second_n;
	logic [11:0] year_n;
	logic [3:0]  month_n;
	logic [4:0]  day_n;
	logic        date_refresh;
	logic [11:0] year_next;
	logic [3:0]  month_next;

	// Advance the staged word once the result register is free or being taken
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Payload needs no reset; capture on every accepted word
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			opcode_s1   <= opcode;
			press_s1    <= press_valid;
			c_hour_s1   <= clock_hour;
			c_minute_s1 <= clock_minute;
			c_second_s1 <= clock_second;
			c_year_s1   <= clock_year;
			c_month_s1  <= clock_month;
			c_day_s1    <= clock_day;
		end
	end

	assign ctl = '{opcode: opcode_s1, press_valid: press_s1, mode: mode_q};

	// Mode machine: the set buttons enter their edit mode from idle and,
	// pressed again in that mode, drop back to idle with a write strobe.
	always_comb begin
		mode_n = mode_q;
		wt_n   = 1'b0;
		wd_n   = 1'b0;
		if (press_s1) begin
			if (opcode_s1 == OP_TIME_SET) begin
				if (mode_q == MODE_IDLE) begin
					mode_n = MODE_TIME;
				end else if (mode_q == MODE_TIME) begin
					mode_n = MODE_IDLE;
					wt_n   = 1'b1;
				end
			end else if (opcode_s1 == OP_DATE_SET) begin
				if (mode_q == MODE_IDLE) begin
					mode_n = MODE_DATE;
				end else if (mode_q == MODE_DATE) begin
					mode_n = MODE_IDLE;
					wd_n   = 1'b1;
				end
			end
		end
	end

	cdsm_time_unit u_time (
		.ctl          (ctl),
		.hour         (hour_q),
		.minute       (minute_q),
		.second       (second_q),
		.clock_hour   (c_hour_s1),
		.clock_minute (c_minute_s1),
		.clock_second (c_second_s1),
		.hour_n       (hour_n),
		.minute_n     (minute_n),
		.second_n     (second_n)
	);

	cdsm_date_unit u_date (
		.ctl         (ctl),
		.year        (year_q),
		.month       (month_q),
		.day         (day_q),
		.clock_year  (c_year_s1),
		.clock_month (c_month_s1),
		.clock_day   (c_day_s1),
		.year_n      (year_n),
		.month_n     (month_n),
		.day_n       (day_n)
	);

	// Refresh of the date takes the clock's year and month; else the date unit's
	assign date_refresh = (opcode_s1 == OP_REFRESH) && (mode_q != MODE_DATE);
	assign year_next    = date_refresh ? c_year_s1 : year_n;
	assign month_next   = date_refresh ? c_month_s1 : month_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			hour_q         <= 5'd0;
			minute_q       <= 6'd0;
			second_q       <= 6'd0;
			year_q         <= 12'd0;
			month_q        <= 4'd0;
			day_q          <= 5'd0;
			wt_q           <= 1'b0;
			wd_q           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			mode_q         <= mode_n;
			hour_q         <= hour_n;
			minute_q       <= minute_n;
			second_q       <= second_n;
			year_q         <= year_next;
			month_q        <= month_next;
			day_q          <= day_n;
			wt_q           <= wt_n;
			wd_q           <= wd_n;
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign mode         = mode_q;
	assign shown_hour   = hour_q;
	assign shown_minute = minute_q;
	assign shown_second = second_q;
	assign shown_year   = year_q;
	assign shown_month  = month_q;
	assign shown_day    = day_q;
	assign write_time   = wt_q;
	assign write_date   = wd_q;

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the clock/date set-mode controller.
module tb;
	import cdsm_pkg::*;

	// Opcode that decodes to nothing
	localparam logic [3:0] OP_NONE = 4'd15;

	localparam int YEAR_FIRST   = 2000;
	localparam int YEAR_LAST    = 2099;
	localparam int HOUR_TOP     = 23;
	localparam int MINSEC_TOP   = 59;
	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// Years on either side of the leap rules, for refresh words
	localparam int EDGE_YEARS [6] = '{1900, 2000, 2004, 2096, 2099, 2100};

	localparam logic [3:0] TIME_STEPS [6] = '{OP_INC_HOUR, OP_INC_MIN, OP_INC_SEC,
		OP_DEC_HOUR, OP_DEC_MIN, OP_DEC_SEC};
	localparam logic [3:0] DATE_STEPS [6] = '{OP_INC_YEAR, OP_INC_MONTH, OP_INC_DAY,
		OP_DEC_YEAR, OP_DEC_MONTH, OP_DEC_DAY};

	localparam int RANDOM_WORDS = 800;
	localparam int PAUSE_AT     = 500;  // sender drains the block here
	localparam int HOLD_AT      = 250;  // receiver holds off at this result
	localparam int LONG_HOLD    = 120;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT   = 2000;

	typedef struct packed {
		logic [3:0]  opcode;
		logic        press_valid;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} set_word_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        write_time;
		logic        write_date;
	} shown_t;

	typedef struct {
		set_word_t w;
		bit        typed;
		shown_t    want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [3:0]  opcode = '0;
	logic        press_valid = 1'b0;
	logic [4:0]  clock_hour = '0;
	logic [5:0]  clock_minute = '0;
	logic [5:0]  clock_second = '0;
	logic [11:0] clock_year = '0;
	logic [3:0]  clock_month = '0;
	logic [4:0]  clock_day = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  mode;
	logic [4:0]  shown_hour;
	logic [5:0]  shown_minute;
	logic [5:0]  shown_second;
	logic [11:0] shown_year;
	logic [3:0]  shown_month;
	logic [4:0]  shown_day;
	logic        write_time;
	logic        write_date;

	// Displayed values the block should produce, oldest first
	shown_t shown_q [$];
	int     fails = 0;
	int     idle_cycles = 0;

	// Bench copy of the block's state
	logic [1:0] sh_mode = MODE_IDLE;
	int sh_hour = 0, sh_min = 0, sh_sec = 0;
	int sh_year = 0, sh_month = 0, sh_day = 0;

	clock_date_set_mode_controller uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.opcode       (opcode),
		.press_valid  (press_valid),
		.clock_hour   (clock_hour),
		.clock_minute (clock_minute),
		.clock_second (clock_second),
		.clock_year   (clock_year),
		.clock_month  (clock_month),
		.clock_day    (clock_day),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.mode         (mode),
		.shown_hour   (shown_hour),
		.shown_minute (shown_minute),
		.shown_second (shown_second),
		.shown_year   (shown_year),
		.shown_month  (shown_month),
		.shown_day    (shown_day),
		.write_time   (write_time),
		.write_date   (write_date)
	);

	always #2 clk = ~clk;

	// Gregorian rule: every fourth year, but not centuries unless divisible by 400
	function automatic bit is_leap(int y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	// A month outside 1..12 counts as a long month
	function automatic int month_length(int y, int m);
		if (m < 1 || m > 12) return 31;
		if (m == 2 && is_leap(y)) return 29;
		return MONTH_DAYS[m - 1];
	endfunction

	function automatic int wrap_up(int v, int top);
		return (v >= top) ? 0 : v + 1;
	endfunction

	function automatic int wrap_down(int v, int top);
		return (v == 0 || v > top) ? top : v - 1;
	endfunction

	// Pull the day back into the month after a year or month change
	function automatic void trim_day();
		int n;
		n = month_length(sh_year, sh_month);
		if (sh_day > n) sh_day = n;
	endfunction

	// Apply one word to the bench state and return what the display should read
	function automatic shown_t advance_display(set_word_t w);
		shown_t r;
		int     n;
		r = '0;
		if (w.opcode == OP_REFRESH) begin
			// Refresh ignores the press flag; hold whichever half is being edited
			if (sh_mode != MODE_TIME) begin
				sh_hour = w.hour;
				sh_min  = w.minute;
				sh_sec  = w.second;
			end
			if (sh_mode != MODE_DATE) begin
				sh_year  = w.year;
				sh_month = w.month;
				sh_day   = w.day;
			end
		end else if (w.press_valid) begin
			case (w.opcode)
				OP_INC_HOUR: if (sh_mode == MODE_TIME) sh_hour = wrap_up(sh_hour, HOUR_TOP);
				OP_INC_MIN:  if (sh_mode == MODE_TIME) sh_min = wrap_up(sh_min, MINSEC_TOP);
				OP_INC_SEC:  if (sh_mode == MODE_TIME) sh_sec = wrap_up(sh_sec, MINSEC_TOP);
				OP_DEC_HOUR: if (sh_mode == MODE_TIME) sh_hour = wrap_down(sh_hour, HOUR_TOP);
				OP_DEC_MIN:  if (sh_mode == MODE_TIME) sh_min = wrap_down(sh_min, MINSEC_TOP);
				OP_DEC_SEC:  if (sh_mode == MODE_TIME) sh_sec = wrap_down(sh_sec, MINSEC_TOP);
				OP_INC_YEAR: if (sh_mode == MODE_DATE) begin
					sh_year = (sh_year >= YEAR_FIRST && sh_year < YEAR_LAST) ?
						sh_year + 1 : YEAR_FIRST;
					trim_day();
				end
				OP_INC_MONTH: if (sh_mode == MODE_DATE) begin
					sh_month = (sh_month >= 12) ? 1 : sh_month + 1;
					trim_day();
				end
				OP_INC_DAY: if (sh_mode == MODE_DATE) begin
					n = month_length(sh_year, sh_month);
					sh_day = (sh_day + 1 > n) ? 1 : sh_day + 1;
				end
				OP_DEC_YEAR: if (sh_mode == MODE_DATE) begin
					sh_year = (sh_year > YEAR_FIRST && sh_year <= YEAR_LAST) ?
						sh_year - 1 : YEAR_LAST;
					trim_day();
				end
				OP_DEC_MONTH: if (sh_mode == MODE_DATE) begin
					sh_month = (sh_month <= 1 || sh_month > 12) ? 12 : sh_month - 1;
					trim_day();
				end
				OP_DEC_DAY: if (sh_mode == MODE_DATE) begin
					sh_day = (sh_day <= 1) ? month_length(sh_year, sh_month) : sh_day - 1;
				end
				OP_TIME_SET: begin
					if (sh_mode == MODE_IDLE) sh_mode = MODE_TIME;
					else if (sh_mode == MODE_TIME) begin
						r.write_time = 1'b1;
						sh_mode = MODE_IDLE;
					end
				end
				OP_DATE_SET: begin
					if (sh_mode == MODE_IDLE) sh_mode = MODE_DATE;
					else if (sh_mode == MODE_DATE) begin
						r.write_date = 1'b1;
						sh_mode = MODE_IDLE;
					end
				end
				default: ;
			endcase
		end
		r.mode   = sh_mode;
		r.hour   = 5'(sh_hour);
		r.minute = 6'(sh_min);
		r.second = 6'(sh_sec);
		r.year   = 12'(sh_year);
		r.month  = 4'(sh_month);
		r.day    = 5'(sh_day);
		return r;
	endfunction

	function automatic set_word_t word_of(logic [3:0] op, logic pv, int h, int m, int s,
		int y, int mo, int d);
		set_word_t w;
		w.opcode = op;
		w.press_valid = pv;
		w.hour = 5'(h);
		w.minute = 6'(m);
		w.second = 6'(s);
		w.year = 12'(y);
		w.month = 4'(mo);
		w.day = 5'(d);
		return w;
	endfunction

	function automatic shown_t shown_of(logic [1:0] md, int h, int m, int s, int y, int mo,
		int d, logic wt, logic wd);
		shown_t r;
		r.mode = md;
		r.hour = 5'(h);
		r.minute = 6'(m);
		r.second = 6'(s);
		r.year = 12'(y);
		r.month = 4'(mo);
		r.day = 5'(d);
		r.write_time = wt;
		r.write_date = wd;
		return r;
	endfunction

	// Mostly steps that suit the current mode, so edit sessions run long
	function automatic set_word_t random_word();
		set_word_t w;
		int        r;
		r = $urandom_range(0, 99);
		w.press_valid = ($urandom_range(0, 11) != 0);
		if (r < 12)
			w.opcode = OP_REFRESH;
		else if (r < 22)
			w.opcode = $urandom_range(0, 1) ? OP_TIME_SET : OP_DATE_SET;
		else if (r < 92) begin
			if (sh_mode == MODE_TIME || (sh_mode == MODE_IDLE && $urandom_range(0, 1)))
				w.opcode = TIME_STEPS[$urandom_range(0, 5)];
			else
				w.opcode = DATE_STEPS[$urandom_range(0, 5)];
		end else
			w.opcode = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 6) == 0) begin
			// Raw bits, which may fall out of range
			w.hour   = 5'($urandom);
			w.minute = 6'($urandom);
			w.second = 6'($urandom);
			w.year   = 12'($urandom);
			w.month  = 4'($urandom);
			w.day    = 5'($urandom);
		end else begin
			w.hour   = 5'($urandom_range(0, HOUR_TOP));
			w.minute = 6'($urandom_range(0, MINSEC_TOP));
			w.second = 6'($urandom_range(0, MINSEC_TOP));
			w.year   = ($urandom_range(0, 3) == 0) ? 12'(EDGE_YEARS[$urandom_range(0, 5)]) :
				12'($urandom_range(YEAR_FIRST, YEAR_LAST));
			w.month  = 4'($urandom_range(1, 12));
			w.day    = 5'($urandom_range(1, 31));
		end
		return w;
	endfunction

	// Idle gap before a word; bursts of back-to-back words every so often
	function automatic int pick_gap(int n);
		if ((n / 128) % 4 == 3) return 0;
		return $urandom_range(0, 5);
	endfunction

	// Offer one word and hold it until the block takes it
	task automatic send_word(input set_word_t w, input int n);
		int gap;
		gap = pick_gap(n);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		opcode       <= w.opcode;
		press_valid  <= w.press_valid;
		clock_hour   <= w.hour;
		clock_minute <= w.minute;
		clock_second <= w.second;
		clock_year   <= w.year;
		clock_month  <= w.month;
		clock_day    <= w.day;
		item_valid   <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic compare_field(input string name, input logic [11:0] want,
		input logic [11:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// Stimulus: directed table first, then random words
	initial begin : stimulus
		dir_row_t  dir_tab [$];
		shown_t    pred;
		set_word_t w;
		int        sent;
		int        counted;
		bit        paused;

		// Nothing decodes, or the press flag is low: display stays at reset
		dir_tab.push_back('{word_of(OP_NONE, 1, 23, 59, 59, 2099, 12, 31), 1'b1,
			shown_of(MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0)});
		dir_tab.push_back('{word_of(OP_TIME_SET, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			shown_of(MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0)});
		// Refresh copies all-ones fields untouched, press flag low
		dir_tab.push_back('{word_of(OP_REFRESH, 0, 31, 63, 63, 4095, 15, 31), 1'b1,
			shown_of(MODE_IDLE, 31, 63, 63, 4095, 15, 31, 0, 0)});
		dir_tab.push_back('{word_of(OP_TIME_SET, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			shown_of(MODE_TIME, 31, 63, 63, 4095, 15, 31, 0, 0)});
		// Out-of-range held time wraps to 0 on increment and to the top on decrement
		dir_tab.push_back('{word_of(OP_INC_HOUR, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			shown_of(MODE_TIME, 0, 63, 63, 4095, 15, 31, 0, 0)});
		dir_tab.push_back('{word_of(OP_DEC_MIN, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			shown_of(MODE_TIME, 0, 59, 63, 4095, 15, 31, 0, 0)});
		dir_tab.push_back('{word_of(OP_INC_SEC, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			shown_of(MODE_TIME, 0, 59, 0, 4095, 15, 31, 0, 0)});
		dir_tab.push_back('{word_of(OP_DEC_HOUR, 1, 0, 0, 0, 0, 0, 0), 1'b1,
			shown_of(MODE_TIME, 23, 59, 0, 4095, 15, 31, 0, 0)});
		// Refresh while editing time: hold time, take the date (a century year)
		dir_tab.push_back('{word_of(OP_REFRESH, 1, 12, 30, 45, 2100, 2, 29), 1'b0, '0});
		// Other set button and date steps do nothing in time edit
		dir_tab.push_back('{word_of(OP_DATE_SET, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_INC_YEAR, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_TIME_SET, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_DATE_SET, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// February of a non-leap century: day 29 rolls to 1, back down to 28
		dir_tab.push_back('{word_of(OP_INC_DAY, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_DEC_DAY, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_INC_YEAR, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// Refresh while editing date: take the time only
		dir_tab.push_back('{word_of(OP_REFRESH, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// 2000 is leap; leaving it clamps the day back to 28
		dir_tab.push_back('{word_of(OP_INC_DAY, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_DEC_YEAR, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_DEC_MONTH, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_DEC_MONTH, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_INC_MONTH, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_INC_SEC, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_TIME_SET, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		dir_tab.push_back('{word_of(OP_DATE_SET, 1, 0, 0, 0, 0, 0, 0), 1'b0, '0});
		// All-zero refresh back in idle
		dir_tab.push_back('{word_of(OP_REFRESH, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			shown_of(MODE_IDLE, 0, 0, 0, 0, 0, 0, 0, 0)});

		// Hold reset low, then release it on a clock edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		sent = 0;
		foreach (dir_tab[i]) begin
			send_word(dir_tab[i].w, sent);
			sent++;
			// Advance the bench state even where the row carries its own answer
			pred = advance_display(dir_tab[i].w);
			shown_q.push_back(dir_tab[i].typed ? dir_tab[i].want : pred);
		end

		counted = 0;
		paused = 1'b0;
		while (counted < RANDOM_WORDS) begin
			if (!paused && counted == PAUSE_AT) begin
				// Drop valid and let every pending result drain
				paused = 1'b1;
				item_valid <= 1'b0;
				do @(posedge clk); while (shown_q.size() != 0);
			end
			w = random_word();
			send_word(w, sent);
			sent++;
			shown_q.push_back(advance_display(w));
			counted++;
		end
		item_valid <= 1'b0;

		// Wait for the last result, then keep watching for anything stray
		while (shown_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && shown_q.size() == 0)
			$display("PASS clock_date_set_mode_controller");
		else
			$display("FAIL clock_date_set_mode_controller");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off, field-by-field check
	initial begin : result_side
		int     got;
		int     gap;
		shown_t want;
		got = 0;
		@(posedge arst_n);
		forever begin
			// Hold off long enough once for the block to fill and stall its input
			gap = (got == HOLD_AT) ? LONG_HOLD : pick_gap(got);
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			got++;
			if (shown_q.size() == 0) begin
				$error("result arrived with no word pending");
				fails++;
			end else begin
				want = shown_q.pop_front();
				compare_field("mode", 12'(want.mode), 12'(mode));
				compare_field("shown_hour", 12'(want.hour), 12'(shown_hour));
				compare_field("shown_minute", 12'(want.minute), 12'(shown_minute));
				compare_field("shown_second", 12'(want.second), 12'(shown_second));
				compare_field("shown_year", want.year, shown_year);
				compare_field("shown_month", 12'(want.month), 12'(shown_month));
				compare_field("shown_day", 12'(want.day), 12'(shown_day));
				compare_field("write_time", 12'(want.write_time), 12'(write_time));
				compare_field("write_date", 12'(want.write_date), 12'(write_date));
			end
		end
	end

	// Watchdog: end the run if neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL clock_date_set_mode_controller");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
